/* hw/rtl/csp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the circle sub-cell permittivity block.
// No dependencies; every other file in hw/rtl imports this package.
package csp_pkg;

    // Sub-sampling grid and coordinate format
    localparam int SUB        = 32;               // sub-samples per axis (power of two)
    localparam int SUB_W      = $clog2(SUB);
    localparam int FRAC       = 6;                // coordinate fraction bits
    localparam int ONE        = 1 << FRAC;
    localparam int SCALE_LOG2 = SUB_W + 1;        // sub-sample units: 1/(2*SUB) of a step
    localparam int TOTAL      = SUB * SUB;
    localparam int TOT_LOG2   = 2 * SUB_W;

    // Field widths
    localparam int POS_W  = 19;
    localparam int RAD_W  = 18;
    localparam int EPS_W  = 25;
    localparam int DOM_W  = 13;
    localparam int BRD_W  = 8;
    localparam int COMP_W = 2;
    localparam int COV_W  = 11;
    localparam int PERM_W = 25;
    localparam int CFG_W  = 25;
    localparam int IDX_W  = 3;

    // Derived datapath widths
    localparam int DX_W   = POS_W + 1;                // centred offset, signed
    localparam int SQD_W  = 2 * (DX_W - 1);           // square of a centred offset
    localparam int D2_W   = SQD_W + 1;                // sum of two squares
    localparam int ROUT_W = RAD_W + 1;
    localparam int SCL_W  = DX_W + SCALE_LOG2 + 1;    // scaled offset plus sub-sample shift
    localparam int MAG_W  = SCL_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int R2_W   = 2 * RAD_W + 2 * SCALE_LOG2;
    localparam int PC_W   = SUB_W + 1;
    localparam int NUM_W  = PERM_W + COV_W + 1;
    localparam int VAC_LOG2 = 16;

    // Component codes
    localparam logic [COMP_W-1:0] COMP_X = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y = 2'd1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_RADIUS     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EPS_INSIDE = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DOM_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DOM_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BORDER     = 3'd4;

    // Configuration reset values
    localparam logic [RAD_W-1:0] RST_RADIUS     = 18'd6400;
    localparam logic [EPS_W-1:0] RST_EPS_INSIDE = 25'd167772;
    localparam logic [DOM_W-1:0] RST_DOM_WIDTH  = 13'd1024;
    localparam logic [DOM_W-1:0] RST_DOM_HEIGHT = 13'd1024;
    localparam logic [BRD_W-1:0] RST_BORDER     = 8'd16;

    // Where a point sits relative to the cylinder
    typedef enum logic [1:0] {
        ZONE_OUT,
        ZONE_IN,
        ZONE_EDGE
    } t_zone;

    // Radius-derived thresholds, refreshed from the radius register
    typedef struct packed {
        logic [2*ROUT_W-1:0] rout2;
        logic [2*RAD_W-1:0]  rin2;
        logic                has_in;
        logic [R2_W-1:0]     r2;
    } t_geom;

    // Request traveling down the cell chain
    typedef struct packed {
        logic signed [DX_W-1:0]  dx;
        logic [COMP_W-1:0]       comp;
        t_zone                   zone;
        logic [SQ_W-1:0]         sx;
        logic [COV_W-1:0]        cnt;
        logic [SUB-1:0][SQ_W-1:0] sy;
    } t_chain;

    // Sub-sample offset of row k in scaled units: (2k+1-SUB) * ONE
    function automatic logic signed [SCL_W-1:0] sub_off(input int k);
        return SCL_W'((2 * k + 1 - SUB) * ONE);
    endfunction

    // Centred offset expressed in scaled units
    function automatic logic signed [SCL_W-1:0] scale_dx(input logic signed [DX_W-1:0] d);
        logic signed [SCL_W-1:0] e;
        e = SCL_W'(d);
        return e <<< SCALE_LOG2;
    endfunction

    // Square of the magnitude of a signed value
    function automatic logic [SQ_W-1:0] sq_mag(input logic signed [SCL_W-1:0] v);
        logic [SCL_W-1:0] m;
        logic [SQ_W-1:0]  p;
        m = v[SCL_W-1] ? SCL_W'(-v) : v;
        p = m[MAG_W-1:0] * m[MAG_W-1:0];
        return p;
    endfunction

endpackage

/* hw/rtl/csp_front.sv */
`timescale 1ns / 1ps
// Front end: domain check, centring, coarse distance test and sub-sample squares.
// Uses csp_pkg; feeds the first csp_cell of the chain.
module csp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [csp_pkg::POS_W-1:0]  i_pos_x,
    input  logic [csp_pkg::POS_W-1:0]  i_pos_y,
    input  logic [csp_pkg::COMP_W-1:0] i_component,
    input  logic [csp_pkg::DOM_W-1:0]  i_dom_width,
    input  logic [csp_pkg::DOM_W-1:0]  i_dom_height,
    input  logic [csp_pkg::BRD_W-1:0]  i_border,
    input  csp_pkg::t_geom             i_geom,
    output logic                       o_valid,
    input  logic                       i_ready,
    output csp_pkg::t_chain            o_data
);
    import csp_pkg::*;

    // Stage 1: shifted and centred coordinates
    logic                    r_v1;
    logic signed [DX_W-1:0]  r_dx1, r_dy1;
    logic                    r_in1;
    logic [COMP_W-1:0]       r_comp1;

    // Stage 2: squares
    logic                    r_v2;
    logic [SQD_W-1:0]        r_sqx2, r_sqy2;
    logic signed [DX_W-1:0]  r_dx2;
    logic [COMP_W-1:0]       r_comp2;
    logic                    r_in2;
    logic [SQ_W-1:0]         r_sx2;
    logic [SUB-1:0][SQ_W-1:0] r_sy2;

    // Stage 3: classified request
    logic                    r_v3;
    t_chain                  r_out;

    logic en1, en2, en3;

    logic signed [DX_W-1:0]  mx, my, n_dx1, n_dy1, brd;
    logic                    n_in1;
    logic [SQ_W-1:0]         sqx_full, sqy_full, n_sx2;
    logic [SUB-1:0][SQ_W-1:0] n_sy2;
    logic [D2_W-1:0]         d2;
    t_zone                   n_zone;

    // Advance a stage when it is empty or the next one moves
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    // Remove the border, check the area, centre
    always_comb begin
        brd   = DX_W'({i_border, {FRAC{1'b0}}});
        mx    = $signed({1'b0, i_pos_x}) - brd;
        my    = $signed({1'b0, i_pos_y}) - brd;
        n_in1 = !mx[DX_W-1] && !my[DX_W-1]
              && (mx[POS_W-1:0] < POS_W'({i_dom_width, {FRAC{1'b0}}}))
              && (my[POS_W-1:0] < POS_W'({i_dom_height, {FRAC{1'b0}}}));
        n_dx1 = mx - $signed(DX_W'({i_dom_width, {(FRAC-1){1'b0}}}));
        n_dy1 = my - $signed(DX_W'({i_dom_height, {(FRAC-1){1'b0}}}));
    end

    // Square the coarse offsets, the first sub-sample row offset and every column offset
    always_comb begin
        sqx_full = sq_mag(SCL_W'(r_dx1));
        sqy_full = sq_mag(SCL_W'(r_dy1));
        n_sx2    = sq_mag(scale_dx(r_dx1) + ((r_comp1 == COMP_Y) ? '0 : sub_off(0)));
        for (int l = 0; l < SUB; l++) begin
            n_sy2[l] = sq_mag(scale_dx(r_dy1) + ((r_comp1 == COMP_X) ? '0 : sub_off(l)));
        end
    end

    // Classify against the outer and inner radius
    always_comb begin
        d2 = {1'b0, r_sqx2} + {1'b0, r_sqy2};
        if (!r_in2) begin
            n_zone = ZONE_OUT;
        end else if (d2 >= D2_W'(i_geom.rout2)) begin
            n_zone = ZONE_OUT;
        end else if (i_geom.has_in && (d2 <= D2_W'(i_geom.rin2))) begin
            n_zone = ZONE_IN;
        end else begin
            n_zone = ZONE_EDGE;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_dx1   <= n_dx1;
            r_dy1   <= n_dy1;
            r_in1   <= n_in1;
            r_comp1 <= i_component;
        end
        if (en2) begin
            r_sqx2  <= sqx_full[SQD_W-1:0];
            r_sqy2  <= sqy_full[SQD_W-1:0];
            r_dx2   <= r_dx1;
            r_comp2 <= r_comp1;
            r_in2   <= r_in1;
            r_sx2   <= n_sx2;
            r_sy2   <= n_sy2;
        end
        if (en3) begin
            r_out.dx   <= r_dx2;
            r_out.comp <= r_comp2;
            r_out.zone <= n_zone;
            r_out.sx   <= r_sx2;
            r_out.cnt  <= '0;
            r_out.sy   <= r_sy2;
        end
    end

endmodule

/* hw/rtl/csp_cell.sv */
`timescale 1ns / 1ps
// One cell of the chain: counts the sub-samples of one row inside the radius.
// Uses csp_pkg; instantiated SUB times by the top level.
module csp_cell #(
    parameter int K = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  csp_pkg::t_chain                 i_data,
    input  logic [csp_pkg::R2_W-1:0]        i_r2,
    output logic                            o_valid,
    input  logic                            i_ready,
    output csp_pkg::t_chain                 o_data
);
    import csp_pkg::*;

    logic            r_valid;
    t_chain          r_data;
    logic            en;
    logic [PC_W-1:0] pc;
    logic [SQ_W:0]   sum_sq;
    t_chain          n_data;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Test this row against every column, add the hits, square the next row offset
    always_comb begin
        pc = '0;
        for (int l = 0; l < SUB; l++) begin
            sum_sq = {1'b0, i_data.sx} + {1'b0, i_data.sy[l]};
            pc     = pc + PC_W'(sum_sq <= (SQ_W + 1)'(i_r2));
        end
        n_data     = i_data;
        n_data.cnt = i_data.cnt + COV_W'(pc);
        n_data.sx  = sq_mag(scale_dx(i_data.dx)
                   + ((i_data.comp == COMP_Y) ? '0 : sub_off(K + 1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

endmodule

/* hw/rtl/csp_blend.sv */
`timescale 1ns / 1ps
// Output stage: picks the coverage by zone and blends the permittivity with vacuum.
// Uses csp_pkg; takes the last cell of the chain.
module csp_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  csp_pkg::t_zone             i_zone,
    input  logic [csp_pkg::COV_W-1:0]  i_count,
    input  logic [csp_pkg::EPS_W-1:0]  i_eps,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [csp_pkg::COV_W-1:0]  o_coverage,
    output logic [csp_pkg::PERM_W-1:0] o_permittivity
);
    import csp_pkg::*;

    logic               r_valid;
    logic [COV_W-1:0]   r_cov;
    logic [PERM_W-1:0]  r_perm;
    logic               en;
    logic [COV_W-1:0]   cov;
    logic [NUM_W-1:0]   num;

    assign en             = !r_valid || i_ready;
    assign o_ready        = en;
    assign o_valid        = r_valid;
    assign o_coverage     = r_cov;
    assign o_permittivity = r_perm;

    // Select coverage by zone
    always_comb begin
        case (i_zone)
            ZONE_OUT:  cov = '0;
            ZONE_IN:   cov = COV_W'(TOTAL);
            ZONE_EDGE: cov = i_count;
            default:   cov = '0;
        endcase
    end

    // Weighted blend; the divide by the sample total is a shift
    assign num = NUM_W'(i_eps) * NUM_W'(cov)
               + (NUM_W'(COV_W'(TOTAL) - cov) << VAC_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cov  <= cov;
            r_perm <= num[TOT_LOG2 +: PERM_W];
        end
    end

endmodule

/* hw/rtl/circle_subcell_permittivity.sv */
`timescale 1ns / 1ps
// Top level: configuration registers, front end, chain of row cells and output blend.
// Uses csp_pkg, csp_front, csp_cell and csp_blend.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one grid point per request:
//   i_pos_x, i_pos_y in cells with 6 fraction bits and i_component.
//   Output channel (o_valid / i_ready) returns o_coverage (sub-samples inside,
//   out of 1024) and o_permittivity (relative, 16 fraction bits).
//   Configuration is a plain write port: i_cfg_wr_en, i_cfg_index, i_cfg_data;
//   write it only while no request is in flight.
//   Throughput: one request per cycle unless the receiver stalls. Each of the
//   32 cells in the chain tests one sub-sample row against all 32 columns, so
//   the chain sets the latency. The pipeline has 36 register stages: 3 front,
//   32 cells, 1 output; the first loads at the accepting edge.
//   Reset (synchronous, active low) empties the pipeline and loads the default
//   geometry. When the receiver stalls, results hold in the output register and
//   requests keep entering until every stage behind it is full.
module circle_subcell_permittivity (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [csp_pkg::POS_W-1:0]  i_pos_x,
    input  logic [csp_pkg::POS_W-1:0]  i_pos_y,
    input  logic [csp_pkg::COMP_W-1:0] i_component,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [csp_pkg::COV_W-1:0]  o_coverage,
    output logic [csp_pkg::PERM_W-1:0] o_permittivity,
    input  logic                       i_cfg_wr_en,
    input  logic [csp_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [csp_pkg::CFG_W-1:0]  i_cfg_data
);
    import csp_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [EPS_W-1:0] r_eps;
    logic [DOM_W-1:0] r_dom_w;
    logic [DOM_W-1:0] r_dom_h;
    logic [BRD_W-1:0] r_border;
    t_geom            r_geom;
    t_geom            n_geom;

    logic [ROUT_W-1:0]  rout;
    logic [RAD_W-1:0]   rin;
    logic [2*RAD_W-1:0] rad_sq;

    t_chain chain_data  [SUB+1];
    logic   chain_valid [SUB+1];
    logic   chain_ready [SUB+1];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RST_RADIUS;
            r_eps    <= RST_EPS_INSIDE;
            r_dom_w  <= RST_DOM_WIDTH;
            r_dom_h  <= RST_DOM_HEIGHT;
            r_border <= RST_BORDER;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RADIUS:     r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_EPS_INSIDE: r_eps    <= i_cfg_data[EPS_W-1:0];
                CFG_DOM_WIDTH:  r_dom_w  <= i_cfg_data[DOM_W-1:0];
                CFG_DOM_HEIGHT: r_dom_h  <= i_cfg_data[DOM_W-1:0];
                CFG_BORDER:     r_border <= i_cfg_data[BRD_W-1:0];
                default: ;
            endcase
        end
    end

    // Derive the radius thresholds; refreshed every cycle from the register
    always_comb begin
        rout          = ROUT_W'(r_radius) + ROUT_W'(ONE);
        rin           = r_radius - RAD_W'(ONE);
        rad_sq        = r_radius * r_radius;
        n_geom.rout2  = rout * rout;
        n_geom.rin2   = rin * rin;
        n_geom.has_in = (r_radius >= RAD_W'(ONE));
        n_geom.r2     = {rad_sq, {(2*SCALE_LOG2){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    csp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_component  (i_component),
        .i_dom_width  (r_dom_w),
        .i_dom_height (r_dom_h),
        .i_border     (r_border),
        .i_geom       (r_geom),
        .o_valid      (chain_valid[0]),
        .i_ready      (chain_ready[0]),
        .o_data       (chain_data[0])
    );

    // One cell per sub-sample row
    for (genvar k = 0; k < SUB; k++) begin : g_cell
        csp_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .i_r2    (r_geom.r2),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    csp_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (chain_valid[SUB]),
        .o_ready        (chain_ready[SUB]),
        .i_zone         (chain_data[SUB].zone),
        .i_count        (chain_data[SUB].cnt),
        .i_eps          (r_eps),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_coverage     (o_coverage),
        .o_permittivity (o_permittivity)
    );

endmodule
